// ===== rtl/mlcd_pkg.sv =====
package mlcd_pkg;

  typedef enum logic [2:0] {
    CMD_PIXEL   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_OUTLINE = 3'd2,
    CMD_CLEAR   = 3'd3,
    CMD_SEND    = 3'd4,
    CMD_TICK    = 3'd5,
    CMD_SLOT    = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_t;

  localparam logic [7:0] VCOM_HI_CMD = 8'hC0;
  localparam logic [7:0] VCOM_LO_CMD = 8'h80;
  localparam logic [15:0] PERIOD_RESET = 16'd1000;
  localparam logic [7:0] STORE_RESET = 8'hFF;

  typedef struct packed {
    logic       first;
    logic       last;
    logic       flast;
  } pkt_flags_t;

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[7-i] = v[i];
    end
    return r;
  endfunction

endpackage

// ===== rtl/mlcd_ram.sv =====
module mlcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/memory_lcd_framebuffer_refresh.sv =====
// Channel   Dir  Handshake                Payload
// s_axis    in   s_axis_tvalid/tready     command,pos_x,pos_y,rect_width,rect_height,
//                                         pixel_on,clear_byte,now_ms
// m_axis    out  m_axis_tvalid/tready     spi_byte; tuser packet_first,packet_last,frame_last
// cfg       in   cfg_we                   refresh_period_ms
// After reset a clearing pass writes 0xFF to every buffer byte.
// A byte slot reads the memory, then registers the output byte and holds it until taken;
// tick, send and ignored items are handled without leaving the idle state. A pixel, and each
// pixel of a rectangle, is read, written and stepped through the read and write ports of the
// framebuffer memory; an outline walks its top, bottom, left and right sides; a clear writes
// every buffer byte. The input is not ready while an item is at work or a result waits.
module memory_lcd_framebuffer_refresh #(
  parameter int PANEL_ROWS     = 128,
  parameter int PANEL_COLS     = 128,
  parameter int BYTES_PER_LINE = 16,
  parameter int ROWS_PER_PAGE  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], pos_x[10:3], pos_y[18:11], rect_width[26:19], rect_height[34:27],
  // pixel_on[35], clear_byte[43:36], now_ms[75:44], zero [79:76]
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // spi_byte[7:0]
  output logic [7:0]  m_axis_tdata,
  // packet_first[0], packet_last[1], frame_last[2]
  output logic [2:0]  m_axis_tuser
);

  localparam int DEPTH    = PANEL_ROWS * BYTES_PER_LINE;
  localparam int AW       = $clog2(DEPTH);
  localparam int SLOT     = BYTES_PER_LINE + 2;
  localparam int PKT      = 2 + ROWS_PER_PAGE * SLOT;
  localparam int PAGES    = PANEL_ROWS / ROWS_PER_PAGE;
  localparam int PW       = $clog2(PAGES + 1);
  localparam int IW       = $clog2(PKT + 1);
  localparam int RW       = $clog2(ROWS_PER_PAGE + 1);
  localparam int OW       = $clog2(SLOT + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_PREP, S_RD, S_WR, S_NEXT, S_CLR, S_SRD, S_SOUT, S_HOLD
  } state_t;

  state_t state;
  logic [15:0] period;
  logic vcom, sending;
  logic [31:0] last_time;
  logic [PW-1:0] page;
  logic [IW-1:0] idx;
  logic [RW-1:0] row;
  logic [OW-1:0] off;
  logic [AW:0] clr_addr;

  logic [7:0] bx, by, bw, bh, ci, cj;
  logic [1:0] edge_n;
  logic on, is_outline;
  logic [7:0] fill_v;

  // Original outline geometry kept for the later edges.
  logic [7:0] y_o, bw_o, bh_o;

  logic [7:0] px, py;
  logic [AW-1:0] pix_addr;
  logic pix_ok;
  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0] ram_wdata, ram_rdata;
  logic [7:0] obyte;
  mlcd_pkg::pkt_flags_t flags;

  logic [2:0]  in_cmd;
  mlcd_pkg::cmd_t in_op;
  logic [7:0]  in_x, in_y, in_w, in_h, in_fill;
  logic        in_on;
  logic [31:0] in_now;
  logic [31:0] elapsed;

  assign in_cmd  = s_axis_tdata[2:0];
  assign in_op   = mlcd_pkg::cmd_t'(in_cmd);
  assign in_x    = s_axis_tdata[10:3];
  assign in_y    = s_axis_tdata[18:11];
  assign in_w    = s_axis_tdata[26:19];
  assign in_h    = s_axis_tdata[34:27];
  assign in_on   = s_axis_tdata[35];
  assign in_fill = s_axis_tdata[43:36];
  assign in_now  = s_axis_tdata[75:44];
  assign elapsed = in_now - last_time;

  assign s_axis_tready = (state == S_IDLE);

  assign px = bx + ci;
  assign py = by + cj;
  assign pix_ok = (32'(px) < 32'(PANEL_COLS)) && (32'(py) < 32'(PANEL_ROWS))
                  && (32'(px[7:3]) < 32'(BYTES_PER_LINE));
  assign pix_addr = AW'(32'(py) * 32'(BYTES_PER_LINE) + 32'(px[7:3]));

  // Frame read address from page, row and column offset.
  logic [AW-1:0] frame_addr;
  assign frame_addr = AW'((32'(page) * 32'(ROWS_PER_PAGE) + 32'(row)) * 32'(BYTES_PER_LINE)
                          + 32'(off) - 32'd1);

  always_comb begin
    ram_we = 1'b0;
    ram_waddr = pix_addr;
    ram_wdata = on ? (ram_rdata & ~(8'd1 << px[2:0])) : (ram_rdata | (8'd1 << px[2:0]));
    ram_raddr = (state == S_SRD || state == S_IDLE) ? frame_addr : pix_addr;
    if (state == S_INIT || state == S_CLR) begin
      ram_we = 1'b1;
      ram_waddr = clr_addr[AW-1:0];
      ram_wdata = fill_v;
    end else if (state == S_WR) begin
      ram_we = pix_ok;
    end
  end

  mlcd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk, .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // Walk limits for the current rectangle or edge.
  logic last_i, last_j;
  assign last_i = (ci == bw - 8'd1);
  assign last_j = (cj == bh - 8'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      period <= mlcd_pkg::PERIOD_RESET;
      vcom <= 1'b0;
      sending <= 1'b0;
      last_time <= '0;
      page <= '0;
      idx <= '0;
      row <= '0;
      off <= '0;
      clr_addr <= '0;
      fill_v <= mlcd_pkg::STORE_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        period <= cfg_wdata;
      end
      case (state)
        S_INIT, S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == (AW+1)'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            bx <= in_x; by <= in_y; on <= in_on;
            bw <= (in_op == mlcd_pkg::CMD_PIXEL) ? 8'd1 : in_w;
            bh <= (in_op == mlcd_pkg::CMD_FILL) ? in_h : 8'd1;
            ci <= '0; cj <= '0; edge_n <= '0;
            is_outline <= (in_op == mlcd_pkg::CMD_OUTLINE);
            if (in_op == mlcd_pkg::CMD_SLOT) begin
              if (sending) state <= S_SRD;
            end else if (!sending) begin
              case (in_op)
                mlcd_pkg::CMD_PIXEL: begin
                  state <= S_RD;
                end
                mlcd_pkg::CMD_FILL: begin
                  if (in_w != 8'd0 && in_h != 8'd0) state <= S_RD;
                end
                mlcd_pkg::CMD_OUTLINE: begin
                  if (in_w != 8'd0 && in_h != 8'd0) state <= S_RD;
                end
                mlcd_pkg::CMD_CLEAR: begin
                  fill_v <= in_fill; clr_addr <= '0; state <= S_CLR;
                end
                mlcd_pkg::CMD_SEND: begin
                  sending <= 1'b1; page <= '0; idx <= '0; row <= '0; off <= '0;
                end
                mlcd_pkg::CMD_TICK: begin
                  if (elapsed >= 32'(period)) begin
                    last_time <= in_now;
                    sending <= 1'b1; page <= '0; idx <= '0; row <= '0; off <= '0;
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_RD: state <= S_WR;
        S_WR: state <= S_NEXT;
        S_NEXT: begin
          state <= S_RD;
          if (!last_i) begin
            ci <= ci + 8'd1;
          end else if (!last_j) begin
            ci <= '0; cj <= cj + 8'd1;
          end else begin
            ci <= '0; cj <= '0;
            if (!is_outline || edge_n == 2'd3) begin
              state <= S_IDLE;
            end else begin
              edge_n <= edge_n + 2'd1;
              case (edge_n)
                2'd0: begin by <= by + bh_o - 8'd1; end
                2'd1: begin by <= y_o; bh <= bh_o; bw <= 8'd1; end
                default: begin bx <= bx + bw_o - 8'd1; end
              endcase
            end
          end
        end
        S_SRD: state <= S_SOUT;
        S_SOUT: begin
          m_axis_tdata <= obyte;
          m_axis_tuser <= {flags.flast, flags.last, flags.first};
          m_axis_tvalid <= 1'b1;
          state <= S_HOLD;
          if (flags.flast) begin
            sending <= 1'b0; page <= '0; idx <= '0; row <= '0; off <= '0;
            vcom <= ~vcom;
          end else if (flags.last) begin
            page <= page + 1'b1; idx <= '0; row <= '0; off <= '0;
          end else begin
            idx <= idx + 1'b1;
            if (idx != '0) begin
              if (off == OW'(SLOT - 1)) begin
                off <= '0; row <= row + 1'b1;
              end else begin
                off <= off + 1'b1;
              end
            end
          end
        end
        S_HOLD: begin
          if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      y_o <= in_y; bw_o <= in_w; bh_o <= in_h;
    end
  end

  always_comb begin
    flags.first = (idx == '0);
    flags.last  = (32'(idx) + 32'd1 >= 32'(PKT));
    flags.flast = flags.last && (32'(page) + 32'd1 >= 32'(PAGES));
    if (idx == '0) begin
      obyte = vcom ? mlcd_pkg::VCOM_HI_CMD : mlcd_pkg::VCOM_LO_CMD;
    end else if (flags.last) begin
      obyte = 8'h00;
    end else if (off == '0) begin
      obyte = mlcd_pkg::mirror8(8'(32'(page) * 32'(ROWS_PER_PAGE) + 32'(row) + 32'd1));
    end else if (32'(off) <= 32'(BYTES_PER_LINE)) begin
      obyte = mlcd_pkg::mirror8(ram_rdata);
    end else begin
      obyte = 8'h00;
    end
  end

  a_busy_no_ready: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
  a_out_only_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> state == S_HOLD) else $error("valid outside hold");
  a_flast_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_SOUT && flags.flast) |=> !sending) else $error("frame did not end");

endmodule

// ===== dv/memory_lcd_framebuffer_refresh_chk.sv =====
module memory_lcd_framebuffer_refresh_chk
  import mlcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [7:0]  m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  output int          errors,
  output int          pending,
  output int          bytes_seen,
  output logic        frame_busy
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS = 128;
  localparam int COLS = 128;
  localparam int LINE_BYTES = 16;
  localparam int PAGE_ROWS = 8;
  localparam int STORE_SIZE = ROWS * LINE_BYTES;
  localparam int SLOT_BYTES = LINE_BYTES + 2;
  localparam int PACKET_LEN = 2 + PAGE_ROWS * SLOT_BYTES;
  localparam int PAGES = ROWS / PAGE_ROWS;

  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       flast;
  } spi_beat_t;

  logic [7:0]  pix_mem [STORE_SIZE];
  logic        vcom;
  logic [31:0] last_tick;
  logic        sending;
  int          page;
  int          byte_idx;
  logic [15:0] period;
  spi_beat_t   spi_q[$];
  int          err_cnt;
  int          got_cnt;

  assign errors = err_cnt;
  assign pending = spi_q.size();
  assign bytes_seen = got_cnt;
  assign frame_busy = sending;

  function automatic logic [7:0] flip_bits(input logic [7:0] v);
    return {<<{v}};
  endfunction

  function automatic void plot(input int x, input int y, input logic dark);
    int a;
    if (x >= COLS || y >= ROWS || (x >> 3) >= LINE_BYTES) return;
    a = y * LINE_BYTES + (x >> 3);
    pix_mem[a][x & 7] = ~dark;
  endfunction

  function automatic void paint(input int x, input int y, input int w, input int h,
                                input logic dark);
    for (int j = 0; j < h; j++)
      for (int i = 0; i < w; i++)
        plot((x + i) & 8'hFF, (y + j) & 8'hFF, dark);
  endfunction

  function automatic logic [7:0] packet_byte(input int pg, input int idx);
    int k, row, off, y, a;
    if (idx == 0) return vcom ? VCOM_HI_CMD : VCOM_LO_CMD;
    if (idx >= PACKET_LEN - 1) return 8'h00;
    k = idx - 1;
    row = k / SLOT_BYTES;
    off = k % SLOT_BYTES;
    y = pg * PAGE_ROWS + row;
    if (off == 0) return flip_bits(8'((y + 1) & 8'hFF));
    if (off <= LINE_BYTES) begin
      a = y * LINE_BYTES + off - 1;
      return a < STORE_SIZE ? flip_bits(pix_mem[a]) : 8'h00;
    end
    return 8'h00;
  endfunction

  function automatic void apply_item(input logic [79:0] d);
    cmd_t        op;
    int          x, y, w, h;
    logic        dark;
    logic [31:0] now;
    spi_beat_t   e;
    op = cmd_t'(d[2:0]);
    x = int'(d[10:3]);
    y = int'(d[18:11]);
    w = int'(d[26:19]);
    h = int'(d[34:27]);
    dark = d[35];
    now = d[75:44];
    if (op == CMD_SLOT) begin
      if (!sending) return;
      e.data = packet_byte(page, byte_idx);
      e.first = byte_idx == 0;
      e.last = byte_idx + 1 >= PACKET_LEN;
      e.flast = e.last && page + 1 >= PAGES;
      spi_q.push_back(e);
      if (e.flast) begin
        sending = 1'b0;
        page = 0;
        byte_idx = 0;
        vcom = ~vcom;
      end else if (e.last) begin
        page++;
        byte_idx = 0;
      end else begin
        byte_idx++;
      end
      return;
    end
    if (sending) return;
    case (op)
      CMD_PIXEL: plot(x, y, dark);
      CMD_FILL: paint(x, y, w, h, dark);
      CMD_OUTLINE: begin
        if (w != 0 && h != 0) begin
          paint(x, y, w, 1, dark);
          paint(x, (y + h - 1) & 8'hFF, w, 1, dark);
          paint(x, y, 1, h, dark);
          paint((x + w - 1) & 8'hFF, y, 1, h, dark);
        end
      end
      CMD_CLEAR: foreach (pix_mem[i]) pix_mem[i] = d[43:36];
      CMD_SEND: begin
        sending = 1'b1;
        page = 0;
        byte_idx = 0;
      end
      CMD_TICK: begin
        if (now - last_tick >= {16'd0, period}) begin
          last_tick = now;
          sending = 1'b1;
          page = 0;
          byte_idx = 0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    spi_beat_t e;
    if (rst) begin
      foreach (pix_mem[i]) pix_mem[i] = STORE_RESET;
      vcom = 1'b0;
      last_tick = '0;
      sending = 1'b0;
      page = 0;
      byte_idx = 0;
      period = PERIOD_RESET;
      spi_q.delete();
      err_cnt = 0;
      got_cnt = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_cnt++;
        if (spi_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected byte %h user %b", $time, m_axis_tdata, m_axis_tuser);
        end else begin
          e = spi_q.pop_front();
          if (m_axis_tdata !== e.data || m_axis_tuser !== {e.flast, e.last, e.first}) begin
            err_cnt++;
            $display("%0t: expected byte %h user %b, actual byte %h user %b", $time,
                     e.data, {e.flast, e.last, e.first}, m_axis_tdata, m_axis_tuser);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) apply_item(s_axis_tdata);
      if (cfg_we) period = cfg_wdata;
    end
  end

endmodule

// ===== dv/memory_lcd_framebuffer_refresh_tb.sv =====
module memory_lcd_framebuffer_refresh_tb;
  import mlcd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 600000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  int          errors;
  int          pending;
  int          bytes_seen;
  logic        frame_busy;

  logic        gaps_on;
  int          hold_cnt;
  int          quiet_cnt;
  int          item_cnt;
  int          frame_cnt;
  logic [31:0] clock_ms;

  memory_lcd_framebuffer_refresh dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  memory_lcd_framebuffer_refresh_chk chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .errors(errors), .pending(pending),
    .bytes_seen(bytes_seen), .frame_busy(frame_busy)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      m_axis_tready = 1'b0;
    end else if (gaps_on && $urandom_range(0, 9) == 0) begin
      hold_cnt = $urandom_range(0, 11);
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt == STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic push_item(input cmd_t op, input logic [7:0] x, input logic [7:0] y,
                           input logic [7:0] w, input logic [7:0] h, input logic dark,
                           input logic [7:0] fill, input logic [31:0] now);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 12);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {4'd0, now, fill, dark, h, w, y, x, op};
    #1;
    while (!s_axis_tready) begin
      @(negedge clk);
      #1;
    end
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    item_cnt++;
  endtask

  task automatic push_cmd(input cmd_t op);
    push_item(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
              8'($urandom), $urandom);
  endtask

  task automatic push_draw();
    logic [7:0] w, h;
    int pick;
    pick = $urandom_range(0, 19);
    w = pick == 0 ? 8'($urandom) : 8'($urandom_range(0, 12));
    h = pick == 1 ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 12));
    if (pick == 0) h = 8'($urandom_range(0, 3));
    if (pick == 2) begin
      w = 8'($urandom_range(0, 3));
      h = 8'($urandom);
    end
    case ($urandom_range(0, 9))
      0, 1, 2: push_item(CMD_PIXEL, 8'($urandom),
                         $urandom_range(0, 1) != 0 ? 8'($urandom_range(0, 127)) :
                         8'($urandom), w, h, 1'($urandom), 8'($urandom), $urandom);
      3, 4, 5: push_item(CMD_FILL, 8'($urandom), 8'($urandom), w, h, 1'($urandom),
                         8'($urandom), $urandom);
      6, 7: push_item(CMD_OUTLINE, 8'($urandom), 8'($urandom), w, h, 1'($urandom),
                      8'($urandom), $urandom);
      8: push_item(CMD_CLEAR, 8'($urandom), 8'($urandom), w, h, 1'($urandom),
                   8'($urandom), $urandom);
      default: begin
        clock_ms = clock_ms + 32'($urandom_range(0, 2000));
        push_item(CMD_TICK, 8'($urandom), 8'($urandom), w, h, 1'($urandom),
                  8'($urandom), clock_ms);
      end
    endcase
  endtask

  task automatic drain_frame();
    if (frame_busy) frame_cnt++;
    while (frame_busy) begin
      if ($urandom_range(0, 19) == 0)
        push_cmd(cmd_t'($urandom_range(0, 7)));
      else
        push_cmd(CMD_SLOT);
    end
  endtask

  task automatic settle_and_config(input logic [15:0] value);
    while (pending != 0 || !s_axis_tready) @(negedge clk);
    repeat (16) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [15:0] periods [2];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    gaps_on = 1'b0;
    hold_cnt = 0;
    item_cnt = 0;
    frame_cnt = 0;
    clock_ms = '0;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    push_item(CMD_SLOT, '0, '0, '0, '0, 1'b0, '0, '0);
    push_item(CMD_PIXEL, '0, '0, '0, '0, 1'b1, '0, '0);
    push_item(CMD_PIXEL, 8'd127, 8'd127, '0, '0, 1'b1, '0, '0);
    push_item(CMD_PIXEL, 8'd128, 8'd5, '0, '0, 1'b1, '0, '0);
    push_item(CMD_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'hFF, '1);
    push_item(CMD_PIXEL, '0, '0, '0, '0, 1'b0, '0, '0);
    push_item(CMD_FILL, 8'd250, 8'd3, 8'd10, 8'd2, 1'b1, '0, '0);
    push_item(CMD_FILL, 8'd4, 8'd254, 8'd3, 8'd6, 1'b1, '0, '0);
    push_item(CMD_FILL, 8'd20, 8'd20, '0, 8'd9, 1'b1, '0, '0);
    push_item(CMD_FILL, 8'd20, 8'd20, 8'd9, '0, 1'b1, '0, '0);
    push_item(CMD_FILL, 8'd0, 8'd60, 8'd255, 8'd2, 1'b1, '0, '0);
    push_item(CMD_FILL, 8'd64, 8'd0, 8'd2, 8'd255, 1'b0, '0, '0);
    push_item(CMD_OUTLINE, 8'd10, 8'd10, 8'd1, 8'd1, 1'b1, '0, '0);
    push_item(CMD_OUTLINE, 8'd5, 8'd5, '0, 8'd7, 1'b1, '0, '0);
    push_item(CMD_OUTLINE, 8'd200, 8'd200, 8'd255, 8'd255, 1'b1, '0, '0);
    push_item(CMD_OUTLINE, 8'd30, 8'd40, 8'd20, 8'd12, 1'b1, '0, '0);
    push_item(CMD_NONE, '1, '1, '1, '1, 1'b1, '1, '1);
    push_item(CMD_TICK, '0, '0, '0, '0, 1'b0, '0, 32'd500);
    push_item(CMD_TICK, '0, '0, '0, '0, 1'b0, '0, 32'd999);
    push_item(CMD_SEND, '0, '0, '0, '0, 1'b0, '0, '0);
    push_item(CMD_SEND, '0, '0, '0, '0, 1'b0, '0, '0);
    push_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0, 8'h00, '0);
    push_item(CMD_TICK, '0, '0, '0, '0, 1'b0, '0, 32'hFFFF_FFFF);
    drain_frame();
    push_item(CMD_CLEAR, '0, '0, '0, '0, 1'b0, 8'hA5, '0);
    push_item(CMD_FILL, 8'd8, 8'd0, 8'd16, 8'd8, 1'b1, '0, '0);

    periods[0] = 16'hFFFF;
    periods[1] = 16'hC000 | 16'($urandom);
    clock_ms = 32'd999;
    for (int ph = 0; ph < 2 && !frame_busy; ph++) begin
      settle_and_config(periods[ph]);
      gaps_on = 1'b1;
      for (int k = 0; k < 75 && !frame_busy; k++) begin
        if ($urandom_range(0, 29) == 0)
          push_cmd($urandom_range(0, 1) != 0 ? CMD_NONE : CMD_SLOT);
        else
          push_draw();
      end
    end
    drain_frame();

    settle_and_config(16'd0);
    gaps_on = 1'b0;
    push_item(CMD_TICK, '0, '0, '0, '0, 1'b0, '0, clock_ms);
    if (frame_busy) frame_cnt++;
    push_cmd(CMD_SEND);
    for (int k = 0; k < 60; k++) begin
      if (k % 10 == 5) push_draw();
      else push_cmd(CMD_SLOT);
    end

    while (pending != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("Run covered %0d input items, %0d frames started and %0d SPI bytes checked,",
             item_cnt, frame_cnt, bytes_seen);
    $display("with draws, clears, idle slots, ticks and refresh periods of 0 up to 65535.");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
